// ===== hw/rtl/isort_pkg.sv =====
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types and constants for the systolic insertion sorter.
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int CAPACITY = 64;                       // cells in the chain
    localparam int CNT_W    = $clog2(CAPACITY + 1);     // count holds 0..CAPACITY
    localparam int VALUE_W  = 32;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic   insert;     // place the new value, push larger ones right
        logic   shift;      // move every value one cell toward the head
        t_value value;      // value offered for insertion
    } t_cell_ctl;

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

endpackage

// ===== hw/rtl/isort_in_if.sv =====
// ----------------------------------------------------------------------------
// isort_in_if
// Input channel: one value per transaction, with the run-end marker.
// ----------------------------------------------------------------------------
interface isort_in_if;

    logic                 valid;
    logic                 ready;
    isort_pkg::t_value    sample_value;
    logic                 run_end;

    modport source (output valid, output sample_value, output run_end, input ready);
    modport sink   (input valid, input sample_value, input run_end, output ready);

endinterface

// ===== hw/rtl/isort_out_if.sv =====
// ----------------------------------------------------------------------------
// isort_out_if
// Output channel: one sorted value per transaction, with run flags.
// ----------------------------------------------------------------------------
interface isort_out_if;

    logic                 valid;
    logic                 ready;
    isort_pkg::t_value    sorted_value;
    logic                 final_flag;
    logic                 overflow_seen;

    modport source (output valid, output sorted_value, output final_flag,
                     output overflow_seen, input ready);
    modport sink   (input valid, input sorted_value, input final_flag,
                    input overflow_seen, output ready);

endinterface

// ===== hw/rtl/isort_cell.sv =====
// ----------------------------------------------------------------------------
// isort_cell
// One sorter cell: holds a value, inserts the broadcast value or takes its
// left neighbor's value on insert, takes its right neighbor's on shift.
// ----------------------------------------------------------------------------
module isort_cell (
    input  logic                 i_clk,
    input  isort_pkg::t_cell_ctl i_ctl,
    input  logic                 i_occupied,
    input  logic                 i_left_lt,
    input  isort_pkg::t_value    i_left_value,
    input  isort_pkg::t_value    i_right_value,
    output logic                 o_lt,
    output isort_pkg::t_value    o_value
);
    import isort_pkg::*;

    t_value r_value;
    t_value n_value;

    // An empty cell counts as larger than any value.
    assign o_lt    = !i_occupied || (i_ctl.value < r_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        priority if (i_ctl.shift) begin
            n_value = i_right_value;
        end else if (i_ctl.insert) begin
            priority if (i_left_lt) begin
                n_value = i_left_value;     // push right
            end else if (o_lt) begin
                n_value = i_ctl.value;      // insertion point
            end else begin
                n_value = r_value;          // smaller or equal: hold
            end
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ===== hw/rtl/integer_sorter.sv =====
// ----------------------------------------------------------------------------
// integer_sorter
// Streaming sorter: collects a run of signed values and returns them in
// ascending order through a chain of insertion cells.
// ----------------------------------------------------------------------------
// Usage: feed a run of signed 32-bit values, one per transaction, and mark the
// last one with run_end. While a run is being collected, the input takes one
// value every cycle; each value is inserted into its sorted place in the cell
// chain in that same cycle. After the marked value is taken, the input stalls
// and the stored values leave from the head of the chain in ascending order,
// one per cycle while the output is ready, the last one with final_flag set.
// The chain either inserts or shifts out in a cycle, never both. Up to
// CAPACITY values are held; values offered while the chain is full are
// dropped (the marked value too), and overflow_seen is then set on every
// result of that run. Equal values are all kept. No clearing is needed after
// reset.
// ----------------------------------------------------------------------------
module integer_sorter (
    input  logic   i_clk,
    input  logic   i_rst_n,
    isort_in_if.sink    i_sample,
    isort_out_if.source o_sorted
);
    import isort_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_dropped;
    logic             n_dropped;

    t_cell_ctl        w_ctl;
    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_full;

    logic             w_lt    [CAPACITY];
    t_value           w_value [CAPACITY];

    // Accept input only while collecting; present results only while draining.
    assign i_sample.ready = (r_state == ST_FILL);
    assign w_in_acc       = i_sample.valid && i_sample.ready;
    assign w_full         = (r_count == CNT_W'(CAPACITY));

    assign o_sorted.valid         = (r_state == ST_DRAIN);
    assign o_sorted.sorted_value  = w_value[0];
    assign o_sorted.final_flag    = (r_count == CNT_W'(1));
    assign o_sorted.overflow_seen = r_dropped;
    assign w_out_acc              = o_sorted.valid && o_sorted.ready;

    // Broadcast to the chain: insert on an accepted value with room left,
    // shift toward the head on every taken result.
    assign w_ctl.insert = w_in_acc && !w_full;
    assign w_ctl.shift  = w_out_acc;
    assign w_ctl.value  = i_sample.sample_value;

    // Cell chain. Cells at or beyond the count are empty.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   w_left_lt;
        t_value w_left_value;
        t_value w_right_value;

        if (g == 0) begin : g_head
            assign w_left_lt    = 1'b0;
            assign w_left_value = '0;
        end else begin : g_body
            assign w_left_lt    = w_lt[g-1];
            assign w_left_value = w_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_value = '0;
        end else begin : g_link
            assign w_right_value = w_value[g+1];
        end

        isort_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_occupied    (CNT_W'(g) < r_count),
            .i_left_lt     (w_left_lt),
            .i_left_value  (w_left_value),
            .i_right_value (w_right_value),
            .o_lt          (w_lt[g]),
            .o_value       (w_value[g])
        );
    end

    // Sequencer: count the held values, note drops, switch to draining on
    // the run end and back once the last result is taken.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        unique case (r_state)
            ST_FILL: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_sample.run_end) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_out_acc) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state   = ST_FILL;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                n_state   = ST_FILL;
                n_count   = '0;
                n_dropped = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

endmodule
